/* rtl/cst_pkg.sv */
// Shared types and constants for the call-site statistics table.
// Holds table sizing, operation and status codes, payload words and the stats row.
// No dependencies.
package cst_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int KEY_W       = 48;
    localparam int CNT_W       = 64;
    localparam int NUM_CNT     = 4;
    localparam int CIDX_W      = $clog2(NUM_CNT);

    localparam logic [3:0] OP_ENTER   = 4'd0;
    localparam logic [3:0] OP_EXIT    = 4'd1;
    localparam logic [3:0] OP_COUNT   = 4'd2;
    localparam logic [3:0] OP_LOOKUP  = 4'd3;
    localparam logic [3:0] OP_STACKOP = 4'd4;
    localparam logic [3:0] OP_MEMRD   = 4'd5;
    localparam logic [3:0] OP_MEMWR   = 4'd6;
    localparam logic [3:0] OP_CLEAR   = 4'd7;
    localparam logic [3:0] OP_RDENTRY = 4'd8;
    localparam logic [3:0] OP_RDCNT   = 4'd9;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [CIDX_W-1:0] CNT_LOOKUP = 2'd0;
    localparam logic [CIDX_W-1:0] CNT_STACK  = 2'd1;
    localparam logic [CIDX_W-1:0] CNT_RDBYTE = 2'd2;
    localparam logic [CIDX_W-1:0] CNT_WRBYTE = 2'd3;

    localparam logic [2:0] ADDR_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_LEVEL  = 3'd4;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [3:0]       operation;
        logic [KEY_W-1:0] routine_key;
        logic [63:0]      timestamp;
        logic [31:0]      byte_amount;
        logic [7:0]       read_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] entry_key;
        logic [63:0]      call_total;
        logic [63:0]      time_total;
        logic [63:0]      time_least;
        logic [63:0]      time_most;
        logic [63:0]      counter_value;
        logic [8:0]       entries_used;
    } t_out_word;

    typedef struct packed {
        logic [CNT_W-1:0] calls;
        logic [CNT_W-1:0] time_sum;
        logic [CNT_W-1:0] time_min;
        logic [CNT_W-1:0] time_max;
    } t_stat_row;

    localparam t_stat_row STAT_INIT = '{
        calls:    '0,
        time_sum: '0,
        time_min: '1,
        time_max: '0
    };

endpackage

/* rtl/cst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the key store and the statistics rows. No dependencies.
module cst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cst_alu.sv */
// Shared 64-bit add / subtract-compare unit of the statistics sequencer.
// Depends on cst_pkg.
module cst_alu (
    input  logic [cst_pkg::CNT_W-1:0] i_a,
    input  logic [cst_pkg::CNT_W-1:0] i_b,
    input  cst_pkg::t_alu_op          i_op,
    output logic [cst_pkg::CNT_W-1:0] o_res,
    output logic                      o_lt
);
    import cst_pkg::*;

    logic [CNT_W-1:0] b_eff;
    logic [CNT_W:0]   sum;

    always_comb begin
        b_eff = (i_op == ALU_SUB) ? ~i_b : i_b;
        sum   = {1'b0, i_a} + {1'b0, b_eff} + {{CNT_W{1'b0}}, (i_op == ALU_SUB)};
    end

    // a < b when the subtraction borrows
    assign o_res = sum[CNT_W-1:0];
    assign o_lt  = ~sum[CNT_W];

endmodule

/* rtl/call_site_statistics_table_top.sv */
// Top level of the call-site statistics table: sequencer, config port, counters.
// Depends on cst_pkg, cst_ram and cst_alu.
// Each word passes DECODE and RESP; count and exit also pass SEARCH, then LOAD, CALLS and WRITE
// unless the table is full (exit also SUM, MIN and MAX); readentry passes RDENT; clear steps
// CLEAR through every used entry. The key search scans one stored key per cycle (key RAM read port).
// One word at a time: the input stalls from acceptance of a word until its response is issued.
// Reset clears control, config, fill count, timing and global counters; RAMs are not cleared.
module call_site_statistics_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cst_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cst_pkg::t_out_word o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cst_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_SEARCH = 12'b0000_0000_0100,
        S_LOAD   = 12'b0000_0000_1000,
        S_CALLS  = 12'b0000_0001_0000,
        S_SUM    = 12'b0000_0010_0000,
        S_MIN    = 12'b0000_0100_0000,
        S_MAX    = 12'b0000_1000_0000,
        S_WRITE  = 12'b0001_0000_0000,
        S_CLEAR  = 12'b0010_0000_0000,
        S_RDENT  = 12'b0100_0000_0000,
        S_RESP   = 12'b1000_0000_0000
    } t_state;

    t_state           r_state;
    logic             r_en;
    logic [1:0]       r_lvl;
    t_in_word         r_word;
    logic [FILL_W-1:0] r_filled;
    logic [FILL_W-1:0] r_scan;
    logic [ADDR_W-1:0] r_slot;
    logic             r_new;
    logic             r_open;
    logic [63:0]      r_start;
    logic [63:0]      r_elapsed;
    logic [CNT_W-1:0] r_cnt [NUM_CNT];
    logic [1:0]       r_status;
    logic             r_show;
    logic [KEY_W-1:0] r_ekey;
    logic [CNT_W-1:0] r_calls;
    logic [CNT_W-1:0] r_sum;
    logic [CNT_W-1:0] r_min;
    logic [CNT_W-1:0] r_max;
    logic [CNT_W-1:0] r_cval;
    logic             r_out_valid;
    t_out_word        r_out;

    logic             accept;
    logic             cfg_wr;
    logic [FILL_W-1:0] n_scan;
    logic             lvl_timed;
    logic             key_nz;
    logic [CIDX_W-1:0] cnt_sel;
    logic [CNT_W-1:0] cnt_inc;
    logic             idx_ok;

    logic [ADDR_W-1:0] key_raddr;
    logic [KEY_W-1:0]  key_rdata;
    logic              key_we;
    logic [ADDR_W-1:0] stat_raddr;
    logic [$bits(t_stat_row)-1:0] stat_rdata;
    t_stat_row         stat_rd;
    logic              stat_we;
    logic [ADDR_W-1:0] stat_waddr;
    t_stat_row         stat_wdata;

    logic [CNT_W-1:0] alu_a;
    logic [CNT_W-1:0] alu_b;
    t_alu_op          alu_op;
    logic [CNT_W-1:0] alu_res;
    logic             alu_lt;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? {30'd0, r_lvl} : {31'd0, r_en};

    assign n_scan    = r_scan + FILL_W'(1);
    assign lvl_timed = r_lvl[1];
    assign key_nz    = (r_word.routine_key != '0);
    assign idx_ok    = (FILL_W'(r_word.read_index) < r_filled);

    always_comb begin
        cnt_sel = CNT_LOOKUP;
        cnt_inc = CNT_W'(1);
        case (r_word.operation)
            OP_STACKOP: cnt_sel = CNT_STACK;
            OP_MEMRD: begin
                cnt_sel = CNT_RDBYTE;
                cnt_inc = CNT_W'(r_word.byte_amount);
            end
            OP_MEMWR: begin
                cnt_sel = CNT_WRBYTE;
                cnt_inc = CNT_W'(r_word.byte_amount);
            end
            OP_RDCNT: cnt_sel = r_word.read_index[CIDX_W-1:0];
            default:  cnt_sel = CNT_LOOKUP;
        endcase
    end

    // RAM addressing
    assign key_raddr  = (r_state == S_DECODE)
                      ? ((r_word.operation == OP_RDENTRY) ? ADDR_W'(r_word.read_index) : '0)
                      : n_scan[ADDR_W-1:0];
    assign stat_raddr = (r_state == S_DECODE) ? ADDR_W'(r_word.read_index)
                                              : r_scan[ADDR_W-1:0];
    assign key_we     = (r_state == S_SEARCH) && (r_scan >= r_filled)
                      && (r_filled < FILL_W'(TABLE_DEPTH));
    assign stat_rd    = t_stat_row'(stat_rdata);

    always_comb begin
        stat_we    = 1'b0;
        stat_waddr = r_slot;
        stat_wdata = '{calls: r_calls, time_sum: r_sum, time_min: r_min, time_max: r_max};
        if (r_state == S_WRITE) begin
            stat_we = 1'b1;
        end else if (r_state == S_CLEAR) begin
            stat_we    = 1'b1;
            stat_waddr = r_scan[ADDR_W-1:0];
            stat_wdata = STAT_INIT;
        end
    end

    cst_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_filled[ADDR_W-1:0]),
        .i_wdata (r_word.routine_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    cst_ram #(.WIDTH($bits(t_stat_row)), .DEPTH(TABLE_DEPTH)) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (stat_we),
        .i_waddr (stat_waddr),
        .i_wdata (stat_wdata),
        .i_raddr (stat_raddr),
        .o_rdata (stat_rdata)
    );

    // shared unit operand select
    always_comb begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
        unique case (r_state)
            S_DECODE: begin
                if (r_word.operation == OP_EXIT) begin
                    alu_a  = r_word.timestamp;
                    alu_b  = r_start;
                    alu_op = ALU_SUB;
                end else begin
                    alu_a = r_cnt[cnt_sel];
                    alu_b = cnt_inc;
                end
            end
            S_CALLS: begin
                alu_a = r_calls;
                alu_b = CNT_W'(1);
            end
            S_SUM: begin
                alu_a = r_sum;
                alu_b = r_elapsed;
            end
            S_MIN: begin
                alu_a  = r_elapsed;
                alu_b  = r_min;
                alu_op = ALU_SUB;
            end
            S_MAX: begin
                alu_a  = r_max;
                alu_b  = r_elapsed;
                alu_op = ALU_SUB;
            end
            default: begin
                alu_a  = '0;
                alu_b  = '0;
                alu_op = ALU_ADD;
            end
        endcase
    end

    cst_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_op  (alu_op),
        .o_res (alu_res),
        .o_lt  (alu_lt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_en        <= 1'b0;
            r_lvl       <= '0;
            r_filled    <= '0;
            r_open      <= 1'b0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_lvl <= pwdata[1:0];
                end else begin
                    r_en <= pwdata[0];
                end
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_word  <= i_in_word;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_status <= ST_IGNORED;
                    r_show   <= 1'b0;
                    r_cval   <= '0;
                    r_scan   <= '0;
                    r_state  <= S_RESP;
                    case (r_word.operation)
                        OP_ENTER: begin
                            if (r_en && lvl_timed && key_nz) begin
                                r_start  <= r_word.timestamp;
                                r_open   <= 1'b1;
                                r_status <= ST_DONE;
                            end
                        end
                        OP_EXIT: begin
                            if (r_en && lvl_timed && key_nz && r_open) begin
                                r_elapsed <= alu_res;
                                r_open    <= 1'b0;
                                r_state   <= S_SEARCH;
                            end
                        end
                        OP_COUNT: begin
                            if (r_en && !lvl_timed && key_nz) begin
                                r_state <= S_SEARCH;
                            end
                        end
                        OP_LOOKUP, OP_STACKOP, OP_MEMRD, OP_MEMWR: begin
                            if (r_en && ((r_word.operation == OP_LOOKUP) ? (r_lvl != 2'd0)
                                                                         : (r_lvl == 2'd3))) begin
                                r_cnt[cnt_sel] <= alu_res;
                                r_cval         <= alu_res;
                                r_status       <= ST_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            if (r_en) begin
                                for (int i = 0; i < NUM_CNT; i++) begin
                                    r_cnt[i] <= '0;
                                end
                                r_status <= ST_DONE;
                                if (r_filled != '0) begin
                                    r_state <= S_CLEAR;
                                end
                            end
                        end
                        OP_RDENTRY: begin
                            if (idx_ok) begin
                                r_status <= ST_DONE;
                                r_state  <= S_RDENT;
                            end else begin
                                r_status <= ST_RANGE;
                            end
                        end
                        OP_RDCNT: begin
                            if (r_word.read_index < 8'(NUM_CNT)) begin
                                r_cval   <= r_cnt[cnt_sel];
                                r_status <= ST_DONE;
                            end else begin
                                r_status <= ST_RANGE;
                            end
                        end
                        default: r_status <= ST_IGNORED;
                    endcase
                end
                S_SEARCH: begin
                    if (r_scan >= r_filled) begin
                        if (r_filled < FILL_W'(TABLE_DEPTH)) begin
                            r_slot   <= r_filled[ADDR_W-1:0];
                            r_new    <= 1'b1;
                            r_filled <= r_filled + FILL_W'(1);
                            r_state  <= S_LOAD;
                        end else begin
                            r_status <= ST_FULL;
                            r_state  <= S_RESP;
                        end
                    end else if (key_rdata == r_word.routine_key) begin
                        r_slot  <= r_scan[ADDR_W-1:0];
                        r_new   <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_scan <= n_scan;
                    end
                end
                S_LOAD: begin
                    r_ekey  <= r_word.routine_key;
                    r_calls <= r_new ? STAT_INIT.calls    : stat_rd.calls;
                    r_sum   <= r_new ? STAT_INIT.time_sum : stat_rd.time_sum;
                    r_min   <= r_new ? STAT_INIT.time_min : stat_rd.time_min;
                    r_max   <= r_new ? STAT_INIT.time_max : stat_rd.time_max;
                    r_state <= S_CALLS;
                end
                S_CALLS: begin
                    r_calls <= alu_res;
                    r_state <= (r_word.operation == OP_COUNT) ? S_WRITE : S_SUM;
                end
                S_SUM: begin
                    r_sum   <= alu_res;
                    r_state <= S_MIN;
                end
                S_MIN: begin
                    if (alu_lt) begin
                        r_min <= r_elapsed;
                    end
                    r_state <= S_MAX;
                end
                S_MAX: begin
                    if (alu_lt) begin
                        r_max <= r_elapsed;
                    end
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_show   <= 1'b1;
                    r_status <= ST_DONE;
                    r_state  <= S_RESP;
                end
                S_CLEAR: begin
                    r_scan <= n_scan;
                    if (n_scan >= r_filled) begin
                        r_state <= S_RESP;
                    end
                end
                S_RDENT: begin
                    r_ekey  <= key_rdata;
                    r_calls <= stat_rd.calls;
                    r_sum   <= stat_rd.time_sum;
                    r_min   <= stat_rd.time_min;
                    r_max   <= stat_rd.time_max;
                    r_show  <= 1'b1;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESP) && (!r_out_valid || !i_out_stall)) begin
            r_out.status        <= r_status;
            r_out.entry_key     <= r_show ? r_ekey  : '0;
            r_out.call_total    <= r_show ? r_calls : '0;
            r_out.time_total    <= r_show ? r_sum   : '0;
            r_out.time_least    <= r_show ? r_min   : '0;
            r_out.time_most     <= r_show ? r_max   : '0;
            r_out.counter_value <= r_cval;
            r_out.entries_used  <= 9'(r_filled);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
